FILE: sv/twiddle_gain_tuner_assert.svh
// Assertion shorthands for the twiddle gain tuner.
// Each one samples on the rising edge of clk and is off while arst_n is low.
`ifndef TWIDDLE_GAIN_TUNER_ASSERT_SVH
`define TWIDDLE_GAIN_TUNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/twg_pkg.sv
`default_nettype none

package twg_pkg;

	// Sizes
	localparam int NUM_GAINS = 3;
	localparam int ACC_WIDTH = 48;
	localparam int GAIN_W = 32;
	localparam int STEP_W = 32;
	localparam int ERR_W = 16;
	localparam int WIN_W = 16;
	localparam int CFG_W = 32;
	localparam int NUM_REGS = 8;
	localparam int REG_IDX_W = 3;
	localparam int IDX_W = (NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 1;
	localparam int SUM_W = STEP_W + $clog2(NUM_GAINS);
	localparam int DELTA_W = STEP_W + 2;

	// Gains that have start registers and output fields
	localparam int GAIN_FIELDS = 3;
	localparam int FIELD_N = (NUM_GAINS < GAIN_FIELDS) ? NUM_GAINS : GAIN_FIELDS;
	// Slot of the integral gain
	localparam int KI_SLOT = 1;

	// Stream widths
	localparam int IN_W = 16;
	localparam int OUT_W = 104;
	localparam int OUT_PAD = OUT_W - GAIN_FIELDS * GAIN_W - 2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_KP_INIT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KI_INIT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KD_INIT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TOL = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_STEP_P = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_STEP_I = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_STEP_D = 3'd7;

	// Reset values and limits
	localparam logic [WIN_W-1:0] WINDOW_RST = 16'd2000;
	localparam logic [WIN_W-1:0] WIN_MIN = 16'd2;
	localparam logic [STEP_W-1:0] TOL_RST = 32'd1311;
	localparam logic [STEP_W-1:0] STEP_P_RST = 32'd6554;
	localparam logic [STEP_W-1:0] STEP_MAX = '1;
	// |e| < 0.001 and |e| > 3.0 in raw Q4.12
	localparam logic [ERR_W-1:0] MAG_LOW_MAX = 16'd4;
	localparam logic [ERR_W-1:0] MAG_HIGH_MIN = 16'd12288;

	typedef logic signed [GAIN_W-1:0] gain_t;
	typedef logic [STEP_W-1:0] step_t;
	typedef logic [ACC_WIDTH-1:0] acc_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic signed [DELTA_W-1:0] delta_t;

	localparam step_t STEP_INIT_RST [GAIN_FIELDS] = '{STEP_P_RST, '0, '0};
	localparam sum_t SUM_RST = SUM_W'(STEP_P_RST);

	// Add a signed delta to a gain and clamp to the signed gain range.
	function automatic gain_t sat_add(gain_t g, delta_t d);
		logic signed [DELTA_W:0] s;
		s = (DELTA_W + 1)'(g) + (DELTA_W + 1)'(d);
		if (s[DELTA_W:GAIN_W-1] == '0 || s[DELTA_W:GAIN_W-1] == '1) begin
			return s[GAIN_W-1:0];
		end
		return s[DELTA_W] ? {1'b1, {(GAIN_W - 1){1'b0}}} : {1'b0, {(GAIN_W - 1){1'b1}}};
	endfunction

endpackage

`default_nettype wire

FILE: sv/twiddle_gain_tuner.sv
// Twiddle tuner for the three gains of a PID loop.
// The slave stream carries one cross-track error sample per transfer. The
// master stream returns one result per sample: the current gains, a flag that
// this sample closed an evaluation window and a flag that tuning is done.
// Squares of the samples in the first half of each window are summed; at the
// window end the sum is compared with the best so far and the gains and probe
// steps move by the twiddle rule.
// Each result is registered: a sample taken in one cycle has its result on
// the master side in the next. One sample per cycle is taken in steady
// state while the master side keeps up. A window-closing sample that changes
// a probe step is held off until the six-stage divide-by-ten step scaler has
// settled on the current step, which it does once its pipeline has refilled
// after the previous step change, register write or reset.
// When the master side stalls, the held result stays and the slave side
// stops until it is taken. Reset and every configuration write reload the
// gains and steps from the start registers and clear the window state.
`default_nettype none
`include "twiddle_gain_tuner_assert.svh"

module twiddle_gain_tuner (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// [15:0] error_sample
	input wire logic [twg_pkg::IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// [31:0] kp_now, [63:32] ki_now, [95:64] kd_now, [96] gains_updated,
	// [97] tuning_done, [103:98] zero
	output logic [twg_pkg::OUT_W-1:0] m_tdata,
	input wire logic cfg_we,
	input wire logic [twg_pkg::REG_IDX_W-1:0] cfg_index,
	input wire logic [twg_pkg::CFG_W-1:0] cfg_wdata
);
	import twg_pkg::*;

	localparam logic [1:0] KIND_FIRST = 2'd0;
	localparam logic [1:0] KIND_BETTER = 2'd1;
	localparam logic [1:0] KIND_RETRY = 2'd2;
	localparam logic [1:0] KIND_WORSE = 2'd3;

	// Configuration registers and their values after this cycle's write
	gain_t gain_init_q [GAIN_FIELDS];
	step_t step_init_q [GAIN_FIELDS];
	logic [WIN_W-1:0] win_q;
	step_t tol_q;
	gain_t gain_init_d [GAIN_FIELDS];
	step_t step_init_d [GAIN_FIELDS];
	logic [WIN_W-1:0] win_d;
	step_t tol_d;
	sum_t sum_init_d;

	// Tuning state
	gain_t gain_q [NUM_GAINS];
	step_t step_q [NUM_GAINS];
	sum_t sum_q;
	logic [WIN_W-1:0] cnt_q;
	acc_t acc_q;
	acc_t best_q;
	logic first_q;
	logic [IDX_W-1:0] idx_q;
	logic dir_q;

	// Result register
	logic out_valid_q;
	gain_t out_gain_q [GAIN_FIELDS];
	logic out_upd_q;
	logic out_done_q;

	// Datapath
	logic accept;
	logic [ERR_W-1:0] mag;
	logic ki_zero;
	logic [2*ERR_W-1:0] sq;
	logic active;
	logic [WIN_W-1:0] wl_eff;
	logic [WIN_W-1:0] cnt_inc;
	logic in_half;
	logic closing;
	logic [ACC_WIDTH:0] acc_sum;
	acc_t acc_add;
	logic [1:0] kind;
	logic step_moves;
	logic [IDX_W:0] idx_inc;
	logic [IDX_W-1:0] next_idx;
	step_t step_cur;
	step_t step_cur_new;
	step_t step_new [NUM_GAINS];
	gain_t gain_new [NUM_GAINS];
	sum_t sum_next;
	logic done_next;
	gain_t out_gain_d [GAIN_FIELDS];
	sum_t sum_chk;
	step_t scale_grow;
	step_t scale_shrink;
	logic scale_valid;
	logic scale_flush;

	// Register write decode
	always_comb begin
		gain_init_d = gain_init_q;
		step_init_d = step_init_q;
		win_d = win_q;
		tol_d = tol_q;
		if (cfg_we) begin
			case (cfg_index)
				REG_KP_INIT: gain_init_d[0] = cfg_wdata;
				REG_KI_INIT: gain_init_d[1] = cfg_wdata;
				REG_KD_INIT: gain_init_d[2] = cfg_wdata;
				REG_WINDOW: win_d = cfg_wdata[WIN_W-1:0];
				REG_TOL: tol_d = cfg_wdata;
				REG_STEP_P: step_init_d[0] = cfg_wdata;
				REG_STEP_I: step_init_d[1] = cfg_wdata;
				REG_STEP_D: step_init_d[2] = cfg_wdata;
				default: tol_d = tol_q;
			endcase
		end
		sum_init_d = '0;
		for (int j = 0; j < FIELD_N; j++) begin
			sum_init_d = sum_init_d + SUM_W'(step_init_d[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < GAIN_FIELDS; j++) begin
				gain_init_q[j] <= '0;
				step_init_q[j] <= STEP_INIT_RST[j];
			end
			win_q <= WINDOW_RST;
			tol_q <= TOL_RST;
		end else begin
			gain_init_q <= gain_init_d;
			step_init_q <= step_init_d;
			win_q <= win_d;
			tol_q <= tol_d;
		end
	end

	// Sample magnitude, square and integral-gain clamp condition
	assign accept = s_tvalid && s_tready;
	assign mag = s_tdata[ERR_W-1] ? (~s_tdata[ERR_W-1:0] + ERR_W'(1)) : s_tdata[ERR_W-1:0];
	assign sq = mag * mag;
	assign ki_zero = (NUM_GAINS > KI_SLOT) && (mag <= MAG_LOW_MAX || mag > MAG_HIGH_MIN);

	// Window position
	assign active = sum_q > SUM_W'(tol_q);
	assign wl_eff = (win_q < WIN_MIN) ? WIN_MIN : win_q;
	assign cnt_inc = cnt_q + WIN_W'(1);
	assign in_half = cnt_inc <= (wl_eff >> 1);
	assign closing = active && (cnt_inc >= wl_eff);

	// Saturating accumulation of the square
	assign acc_sum = {1'b0, acc_q} + (ACC_WIDTH + 1)'(sq);
	assign acc_add = acc_sum[ACC_WIDTH] ? '1 : acc_sum[ACC_WIDTH-1:0];

	// Outcome of a window close
	always_comb begin
		if (first_q) begin
			kind = KIND_FIRST;
		end else if (acc_q < best_q) begin
			kind = KIND_BETTER;
		end else if (!dir_q) begin
			kind = KIND_RETRY;
		end else begin
			kind = KIND_WORSE;
		end
	end

	assign step_moves = closing && (kind == KIND_BETTER || kind == KIND_WORSE);
	assign idx_inc = {1'b0, idx_q} + (IDX_W + 1)'(1);
	assign next_idx = (idx_inc >= (IDX_W + 1)'(NUM_GAINS)) ? '0 : idx_inc[IDX_W-1:0];
	assign step_cur = step_q[idx_q];
	assign step_cur_new = (kind == KIND_BETTER) ? scale_grow : scale_shrink;
	assign sum_next = step_moves ? (sum_q - SUM_W'(step_cur) + SUM_W'(step_cur_new)) : sum_q;
	assign done_next = sum_next <= SUM_W'(tol_q);

	// Per-gain update: clamp, probe on the current gain, then the first probe
	// of the next gain with its possibly rescaled step.
	always_comb begin
		delta_t d1, d2;
		gain_t g0, g1;
		for (int j = 0; j < NUM_GAINS; j++) begin
			step_new[j] = step_q[j];
			if (step_moves && idx_q == IDX_W'(j)) begin
				step_new[j] = step_cur_new;
			end
			g0 = (j == KI_SLOT && ki_zero) ? '0 : gain_q[j];
			d1 = '0;
			if (closing && idx_q == IDX_W'(j)) begin
				case (kind)
					KIND_FIRST, KIND_WORSE: d1 = $signed({2'b00, step_q[j]});
					KIND_RETRY: d1 = -$signed({1'b0, step_q[j], 1'b0});
					default: d1 = '0;
				endcase
			end
			d2 = '0;
			if (step_moves && next_idx == IDX_W'(j)) begin
				d2 = $signed({2'b00, step_new[j]});
			end
			g1 = sat_add(g0, d1);
			gain_new[j] = sat_add(g1, d2);
		end
	end

	// Tuning state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_GAINS; j++) begin
				gain_q[j] <= '0;
				if (j < FIELD_N) begin
					step_q[j] <= STEP_INIT_RST[j];
				end else begin
					step_q[j] <= '0;
				end
			end
			sum_q <= SUM_RST;
			cnt_q <= '0;
			acc_q <= '0;
			first_q <= 1'b1;
			idx_q <= '0;
			dir_q <= 1'b0;
		end else if (cfg_we) begin
			for (int j = 0; j < NUM_GAINS; j++) begin
				if (j < FIELD_N) begin
					gain_q[j] <= gain_init_d[j];
					step_q[j] <= step_init_d[j];
				end else begin
					gain_q[j] <= '0;
					step_q[j] <= '0;
				end
			end
			sum_q <= sum_init_d;
			cnt_q <= '0;
			acc_q <= '0;
			first_q <= 1'b1;
			idx_q <= '0;
			dir_q <= 1'b0;
		end else if (accept) begin
			gain_q <= gain_new;
			step_q <= step_new;
			sum_q <= sum_next;
			if (closing) begin
				cnt_q <= '0;
				acc_q <= '0;
				case (kind)
					KIND_FIRST: begin
						first_q <= 1'b0;
						dir_q <= 1'b0;
					end
					KIND_RETRY: dir_q <= 1'b1;
					default: begin
						idx_q <= next_idx;
						dir_q <= 1'b0;
					end
				endcase
			end else if (active) begin
				cnt_q <= cnt_inc;
				if (in_half) begin
					acc_q <= acc_add;
				end
			end
		end
	end

	// Best window sum so far; only read after the first window has set it.
	always_ff @(posedge clk) begin
		if (accept && closing && (kind == KIND_FIRST || kind == KIND_BETTER)) begin
			best_q <= acc_q;
		end
	end

	// Step rescaling for the current gain
	assign scale_flush = cfg_we || (accept && step_moves);

	twg_step_scale u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.flush(scale_flush),
		.step_in(step_cur),
		.grow(scale_grow),
		.shrink(scale_shrink),
		.valid(scale_valid)
	);

	// Result register
	always_comb begin
		for (int j = 0; j < GAIN_FIELDS; j++) begin
			out_gain_d[j] = '0;
		end
		for (int j = 0; j < FIELD_N; j++) begin
			out_gain_d[j] = gain_new[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_gain_q <= out_gain_d;
			out_upd_q <= closing;
			out_done_q <= done_next;
		end
	end

	// A new sample enters when the result slot frees up, unless it closes a
	// window that rescales a step before the scaled steps are ready.
	assign s_tready = (!out_valid_q || m_tready) && !(step_moves && !scale_valid);
	assign m_tvalid = out_valid_q;
	assign m_tdata = {{OUT_PAD{1'b0}}, out_done_q, out_upd_q,
		out_gain_q[2], out_gain_q[1], out_gain_q[0]};

	// Full step sum for checking the running sum
	always_comb begin
		sum_chk = '0;
		for (int j = 0; j < NUM_GAINS; j++) begin
			sum_chk = sum_chk + SUM_W'(step_q[j]);
		end
	end

	`TWG_ASSERT_SAME(a_sum_tracks_steps, 1'b1, sum_q == sum_chk, "running step sum differs from step store")
	`TWG_ASSERT_NEXT(a_step_change_flushes, accept && step_moves, !scale_valid, "step scaler kept a stale step")
	`TWG_ASSERT_NEXT(a_close_clears_window, accept && closing, cnt_q == '0 && acc_q == '0, "window state not cleared at close")
	`TWG_ASSERT_NEXT(a_done_freezes_window, accept && !active && !cfg_we, $stable(cnt_q) && $stable(acc_q), "window state moved after tuning finished")
	`TWG_ASSERT_SAME(a_index_in_range, 1'b1, {1'b0, idx_q} < (IDX_W + 1)'(NUM_GAINS), "gain index past last gain")

endmodule

`default_nettype wire

FILE: sv/twg_step_scale.sv
`default_nettype none

module twg_step_scale (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic flush,
	input wire twg_pkg::step_t step_in,
	output twg_pkg::step_t grow,
	output twg_pkg::step_t shrink,
	output logic valid
);
	import twg_pkg::*;

	localparam int X_W = STEP_W + 4;
	localparam int LANES = 2;
	localparam int LAT = 6;
	localparam logic [3:0] MUL_GROW = 4'd11;
	localparam logic [3:0] MUL_SHRINK = 4'd9;
	localparam logic [X_W-1:0] ROUND = X_W'(5);
	localparam logic [X_W-1:0] TEN_M1 = X_W'(9);

	step_t src_s1;
	logic [X_W-1:0] x_s2 [LANES];
	logic [X_W-1:0] x_s3 [LANES];
	logic [X_W-1:0] x_s4 [LANES];
	logic [X_W-1:0] x_s5 [LANES];
	logic [X_W-1:0] q_s3 [LANES];
	logic [X_W-1:0] q_s4 [LANES];
	logic [X_W-1:0] q_s5 [LANES];
	logic [X_W-1:0] q_s6 [LANES];
	logic [X_W-1:0] x_d [LANES];
	logic [X_W-1:0] q3_d [LANES];
	logic [X_W-1:0] q4_d [LANES];
	logic [X_W-1:0] q5_d [LANES];
	logic [X_W-1:0] q6_d [LANES];
	logic [LAT-1:0] v_q;

	// Lane 0 computes (11*s+5)/10, lane 1 computes (9*s+5)/10.
	// The divide by ten is a shift-and-add reciprocal with one remainder correction.
	always_comb begin
		logic [3:0] mul;
		logic [X_W-1:0] t3, t4, rem;
		for (int l = 0; l < LANES; l++) begin
			mul = (l == 0) ? MUL_GROW : MUL_SHRINK;
			x_d[l] = X_W'(src_s1) * X_W'(mul) + ROUND;
			t3 = (x_s2[l] >> 1) + (x_s2[l] >> 2);
			q3_d[l] = t3 + (t3 >> 4);
			t4 = q_s3[l] + (q_s3[l] >> 8);
			q4_d[l] = t4 + (t4 >> 16);
			q5_d[l] = (q_s4[l] + (q_s4[l] >> 32)) >> 3;
			rem = x_s5[l] - ((q_s5[l] << 3) + (q_s5[l] << 1));
			q6_d[l] = q_s5[l] + ((rem > TEN_M1) ? X_W'(1) : X_W'(0));
		end
	end

	// Data pipeline
	always_ff @(posedge clk) begin
		src_s1 <= step_in;
		for (int l = 0; l < LANES; l++) begin
			x_s2[l] <= x_d[l];
			x_s3[l] <= x_s2[l];
			q_s3[l] <= q3_d[l];
			x_s4[l] <= x_s3[l];
			q_s4[l] <= q4_d[l];
			x_s5[l] <= x_s4[l];
			q_s5[l] <= q5_d[l];
			q_s6[l] <= q6_d[l];
		end
	end

	// A change of the source step empties the pipeline; results count once it refills.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (flush) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[LAT-2:0], 1'b1};
		end
	end

	assign grow = (q_s6[0] > X_W'(STEP_MAX)) ? STEP_MAX : q_s6[0][STEP_W-1:0];
	assign shrink = q_s6[1][STEP_W-1:0];
	assign valid = v_q[LAT-1];

endmodule

`default_nettype wire

FILE: verif/twiddle_gain_tuner_test.sv
`timescale 1ns / 1ps

module twiddle_gain_tuner_test;
	import twg_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AT = 250;
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 32;
	localparam int REPORT_MAX = 10;
	localparam acc_t ACC_FULL = '1;

	// Packed so that kp_now lands in the lowest bits, as on m_tdata.
	typedef struct packed {
		logic done;
		logic updated;
		gain_t kd;
		gain_t ki;
		gain_t kp;
	} tuner_result_t;

	typedef struct {
		logic [IN_W-1:0] sample;
		bit drain_first;
	} sample_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	twiddle_gain_tuner dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Stimulus and scoreboard storage.
	sample_req_t samples_pending[$];
	tuner_result_t gains_due[$];
	int idle_pct = 0;
	int fail_count = 0;
	int results_seen = 0;
	int cycle_count = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_taken = 1'b0;

	// Predictor state.
	logic [CFG_W-1:0] tuner_regs [NUM_REGS];
	gain_t gain_now [NUM_GAINS];
	step_t probe_step [NUM_GAINS];
	logic [WIN_W-1:0] window_count;
	acc_t sq_error_sum;
	acc_t best_sq_error;
	bit first_window_open;
	int unsigned active_gain;
	bit tried_minus;

	initial begin
		forever #6 clk = ~clk;
	end

	// Clamp a wide sum into the signed gain range and store it.
	function automatic void bump_gain(int unsigned slot, longint delta);
		longint total;
		total = gain_now[slot];
		total = total + delta;
		if (total > longint'(32'sh7FFF_FFFF)) total = longint'(32'sh7FFF_FFFF);
		if (total < -longint'(64'h8000_0000)) total = -longint'(64'h8000_0000);
		gain_now[slot] = total[GAIN_W-1:0];
	endfunction

	function automatic logic [STEP_W+1:0] step_total();
		logic [STEP_W+1:0] total;
		total = '0;
		for (int g = 0; g < NUM_GAINS; g++) total = total + probe_step[g];
		return total;
	endfunction

	function automatic int unsigned following_gain(int unsigned slot);
		return (slot + 1 >= NUM_GAINS) ? 0 : slot + 1;
	endfunction

	// Load gains and steps from the start registers and clear the window state.
	function automatic void reload_tuner();
		gain_now[0] = tuner_regs[REG_KP_INIT];
		gain_now[1] = tuner_regs[REG_KI_INIT];
		gain_now[2] = tuner_regs[REG_KD_INIT];
		probe_step[0] = tuner_regs[REG_STEP_P];
		probe_step[1] = tuner_regs[REG_STEP_I];
		probe_step[2] = tuner_regs[REG_STEP_D];
		window_count = '0;
		sq_error_sum = '0;
		best_sq_error = '0;
		first_window_open = 1'b1;
		active_gain = 0;
		tried_minus = 1'b0;
	endfunction

	function automatic void reset_tuner_model();
		tuner_regs[REG_KP_INIT] = '0;
		tuner_regs[REG_KI_INIT] = '0;
		tuner_regs[REG_KD_INIT] = '0;
		tuner_regs[REG_WINDOW] = CFG_W'(WINDOW_RST);
		tuner_regs[REG_TOL] = TOL_RST;
		tuner_regs[REG_STEP_P] = STEP_P_RST;
		tuner_regs[REG_STEP_I] = '0;
		tuner_regs[REG_STEP_D] = '0;
		reload_tuner();
	endfunction

	function automatic void apply_config(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		if (idx == REG_WINDOW) begin
			tuner_regs[idx] = CFG_W'(data[WIN_W-1:0]);
		end else begin
			tuner_regs[idx] = data;
		end
		reload_tuner();
	endfunction

	// Twiddle decision at the end of a window.
	function automatic void close_window();
		int unsigned slot;
		logic [63:0] grown;
		slot = active_gain;
		if (first_window_open) begin
			best_sq_error = sq_error_sum;
			first_window_open = 1'b0;
			bump_gain(slot, longint'(probe_step[slot]));
			tried_minus = 1'b0;
		end else if (sq_error_sum < best_sq_error) begin
			grown = (64'(probe_step[slot]) * 64'd11 + 64'd5) / 64'd10;
			probe_step[slot] = (grown > 64'(STEP_MAX)) ? STEP_MAX : grown[STEP_W-1:0];
			best_sq_error = sq_error_sum;
			active_gain = following_gain(slot);
			bump_gain(active_gain, longint'(probe_step[active_gain]));
			tried_minus = 1'b0;
		end else if (!tried_minus) begin
			bump_gain(slot, -2 * longint'(probe_step[slot]));
			tried_minus = 1'b1;
		end else begin
			bump_gain(slot, longint'(probe_step[slot]));
			grown = (64'(probe_step[slot]) * 64'd9 + 64'd5) / 64'd10;
			probe_step[slot] = grown[STEP_W-1:0];
			active_gain = following_gain(slot);
			bump_gain(active_gain, longint'(probe_step[active_gain]));
			tried_minus = 1'b0;
		end
		sq_error_sum = '0;
		window_count = '0;
	endfunction

	// Expected gains and flags after one error sample.
	function automatic tuner_result_t predict_tuner(logic [IN_W-1:0] raw);
		tuner_result_t r;
		int e_val;
		int mag;
		logic [WIN_W-1:0] span;
		logic [63:0] sq;
		logic [63:0] room;
		logic closed;
		e_val = $signed(raw);
		mag = (e_val < 0) ? -e_val : e_val;
		closed = 1'b0;
		// The integral gain is dropped for tiny or huge errors.
		if (mag <= int'(MAG_LOW_MAX) || mag > int'(MAG_HIGH_MIN)) gain_now[KI_SLOT] = '0;
		if (step_total() > tuner_regs[REG_TOL]) begin
			span = tuner_regs[REG_WINDOW][WIN_W-1:0];
			if (span < WIN_MIN) span = WIN_MIN;
			window_count = window_count + 1'b1;
			if (window_count <= span / 2) begin
				sq = 64'(mag) * 64'(mag);
				room = 64'(ACC_FULL) - 64'(sq_error_sum);
				if (sq > room) begin
					sq_error_sum = ACC_FULL;
				end else begin
					sq_error_sum = sq_error_sum + sq[ACC_WIDTH-1:0];
				end
			end
			if (window_count >= span) begin
				close_window();
				closed = 1'b1;
			end
		end
		r.kp = gain_now[0];
		r.ki = gain_now[1];
		r.kd = gain_now[2];
		r.updated = closed;
		r.done = (step_total() <= tuner_regs[REG_TOL]);
		return r;
	endfunction

	function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
		if (fail_count < REPORT_MAX) begin
			$display("mismatch on %s: expected %h, got %h", field, want, got);
		end
		fail_count++;
	endfunction

	function automatic void check_result(tuner_result_t got);
		tuner_result_t want;
		if (gains_due.size() == 0) begin
			if (fail_count < REPORT_MAX) begin
				$display("result with nothing pending: %h", got);
			end
			fail_count++;
			return;
		end
		want = gains_due.pop_front();
		if (got.kp !== want.kp) note_mismatch("kp_now", want.kp, got.kp);
		if (got.ki !== want.ki) note_mismatch("ki_now", want.ki, got.ki);
		if (got.kd !== want.kd) note_mismatch("kd_now", want.kd, got.kd);
		if (got.updated !== want.updated) begin
			note_mismatch("gains_updated", 32'(want.updated), 32'(got.updated));
		end
		if (got.done !== want.done) begin
			note_mismatch("tuning_done", 32'(want.done), 32'(got.done));
		end
	endfunction

	// Observe configuration writes, accepted samples and accepted results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) apply_config(cfg_index, cfg_wdata);
			if (m_tvalid && m_tready) begin
				check_result(m_tdata[$bits(tuner_result_t)-1:0]);
				results_seen <= results_seen + 1;
			end
			if (s_tvalid && s_tready) gains_due.push_back(predict_tuner(s_tdata));
		end
	end

	// Sample driver with random gaps; a marked sample waits for a full drain.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (samples_pending.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (samples_pending[0].drain_first &&
					(s_tvalid || m_tvalid || gains_due.size() != 0)) begin
				s_tvalid <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				gap_left <= $urandom_range(1, 12) - 1;
				s_tvalid <= 1'b0;
			end else begin
				s_tdata <= samples_pending[0].sample;
				s_tvalid <= 1'b1;
				void'(samples_pending.pop_front());
			end
		end
	end

	// Result receiver: random stalls plus one long hold-off while samples keep coming.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_taken && results_seen >= HOLD_AT && s_tvalid) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left <= $urandom_range(1, 12) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Settled view between edges: nothing queued, in flight or pending.
	task automatic wait_tuner_idle();
		do @(negedge clk);
		while (!(samples_pending.size() == 0 && !s_tvalid && !m_tvalid && gains_due.size() == 0));
	endtask

	// Give the step scaler time to settle before touching the registers.
	task automatic settle_for_write();
		wait_tuner_idle();
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic open_phase(int pct);
		@(negedge clk);
		idle_pct = pct;
	endtask

	task automatic queue_sample(logic [IN_W-1:0] v, bit drain);
		sample_req_t req;
		req.sample = v;
		req.drain_first = drain;
		samples_pending.push_back(req);
	endtask

	function automatic logic [CFG_W-1:0] pick_reg_value(logic [REG_IDX_W-1:0] idx);
		logic [CFG_W-1:0] v;
		case (idx)
			REG_KP_INIT, REG_KI_INIT, REG_KD_INIT: begin
				case ($urandom_range(0, 3))
					0: v = $urandom;
					1: v = $urandom_range(0, 32'h6_0000) - 32'h3_0000;
					2: v = 32'h7FFF_FFFF - $urandom_range(0, 32'h2_0000);
					default: v = 32'h8000_0000 + $urandom_range(0, 32'h2_0000);
				endcase
			end
			REG_WINDOW: begin
				case ($urandom_range(0, 19))
					0: v = 32'(16'hFFFF);
					1: v = $urandom_range(10, 40);
					default: v = $urandom_range(0, 8);
				endcase
				// Bits above the register width are discarded by the block.
				if ($urandom_range(0, 3) == 0) v[CFG_W-1:WIN_W] = (CFG_W - WIN_W)'($urandom);
			end
			REG_TOL: begin
				case ($urandom_range(0, 9))
					0: v = 32'hFFFF_FFFF;
					1: v = '0;
					default: v = $urandom_range(0, 32'h4000);
				endcase
			end
			default: begin
				case ($urandom_range(0, 9))
					0: v = 32'hFFFF_FFFF;
					1: v = '0;
					2: v = $urandom;
					default: v = $urandom_range(0, 32'h3_0000);
				endcase
			end
		endcase
		return v;
	endfunction

	// Write a random, nonempty subset of the registers.
	task automatic shuffle_settings();
		bit wrote;
		wrote = 1'b0;
		for (int r = 0; r < NUM_REGS; r++) begin
			if ($urandom_range(0, 1) == 1 || (r == NUM_REGS - 1 && !wrote)) begin
				write_reg(REG_IDX_W'(r), pick_reg_value(REG_IDX_W'(r)));
				wrote = 1'b1;
			end
		end
	endtask

	// Mix of full-range errors, errors around the integral cutoffs and moderate ones.
	function automatic logic [IN_W-1:0] pick_sample();
		int mag;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick <= 2) return IN_W'($urandom);
		if (pick <= 4) begin
			case ($urandom_range(0, 2))
				0: mag = $urandom_range(0, 6);
				1: mag = $urandom_range(12286, 12290);
				default: mag = $urandom_range(32767, 32768);
			endcase
		end else begin
			mag = $urandom_range(0, 4096);
		end
		return ($urandom_range(0, 1) == 1) ? IN_W'(-mag) : IN_W'(mag);
	endfunction

	function automatic int pick_idle();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 15;
			2: return 30;
			default: return 50;
		endcase
	endfunction

	initial begin
		reset_tuner_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: extreme errors, no window closes.
		open_phase(20);
		queue_sample(16'sh7FFF, 1'b0);
		queue_sample(16'sh8000, 1'b0);
		queue_sample(16'h0000, 1'b0);
		queue_sample(16'd12288, 1'b0);

		// Shortest window with saturating gains and a full-scale step.
		settle_for_write();
		write_reg(REG_KP_INIT, 32'h7FFF_0000);
		write_reg(REG_KI_INIT, 32'h0001_2345);
		write_reg(REG_KD_INIT, 32'h8000_8000);
		write_reg(REG_WINDOW, 32'd1);
		write_reg(REG_TOL, 32'd0);
		write_reg(REG_STEP_P, 32'hFFFF_FFFF);
		write_reg(REG_STEP_I, 32'h0000_8000);
		write_reg(REG_STEP_D, 32'h0000_4000);
		open_phase(20);
		queue_sample(16'd5, 1'b0);
		queue_sample(-16'sd5, 1'b0);
		queue_sample(16'd12289, 1'b0);
		queue_sample(-16'sd12288, 1'b0);
		queue_sample(16'd4, 1'b0);
		queue_sample(16'd1, 1'b0);
		queue_sample(-16'sd1, 1'b0);
		queue_sample(16'sh7FFF, 1'b0);
		queue_sample(16'sh8000, 1'b0);
		queue_sample(16'd100, 1'b0);
		queue_sample(16'd5000, 1'b0);
		queue_sample(-16'sd5000, 1'b0);

		// Zero window length and a tolerance that already counts as done.
		settle_for_write();
		write_reg(REG_WINDOW, 32'd0);
		write_reg(REG_STEP_P, 32'd1);
		write_reg(REG_STEP_I, 32'd0);
		write_reg(REG_TOL, 32'hFFFF_FFFF);
		write_reg(REG_KI_INIT, 32'h0003_0000);
		open_phase(20);
		queue_sample(16'd7, 1'b0);
		queue_sample(16'd3, 1'b0);
		queue_sample(-16'sd12289, 1'b0);
		queue_sample(16'd20, 1'b0);
		queue_sample(16'd0, 1'b0);
		queue_sample(16'd1, 1'b0);

		// Random phases; the last one runs without idling.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle_for_write();
			shuffle_settings();
			open_phase((ph == RANDOM_PHASES - 1) ? 0 : pick_idle());
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				queue_sample(pick_sample(), ph == 5 && k == 12);
			end
		end

		wait_tuner_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && gains_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/twg_pkg.sv
sv/twg_step_scale.sv
sv/twiddle_gain_tuner.sv
verif/twiddle_gain_tuner_test.sv
